/* design/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the prime field alu
// Element widths, action codes, sequencer states and the command and result
// structs that pass between the sequencer and the serial modular unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int ELEM_W = 16;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 6;
   localparam int ACT_W  = 3;

   // number of operand bits fed to the serial unit per phase
   localparam logic [CNT_W-1:0] CNT_ELEM = CNT_W'(ELEM_W);
   localparam logic [CNT_W-1:0] CNT_SUM  = CNT_W'(ELEM_W + 1);
   localparam logic [CNT_W-1:0] CNT_WORD = CNT_W'(WORD_W);

   localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1);
   localparam logic [ELEM_W-1:0] ELEM_TWO = ELEM_W'(2);

   localparam logic [ACT_W-1:0] ACT_ADD  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_MUL  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_NEG  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MAP  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_ZERO = 3'd4;
   localparam logic [ACT_W-1:0] ACT_INV  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_REDX,
      ST_MAP,
      ST_MULT,
      ST_INV_MUL,
      ST_INV_SQR,
      ST_DONE
   } pfa_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] bits;
      logic [CNT_W-1:0]  count;
      logic [ELEM_W-1:0] addend;
   } pfa_cmd_type;

   typedef struct packed {
      logic              done;
      logic [ELEM_W-1:0] value;
   } pfa_res_type;

endpackage

/* design/pfa_channels.sv */
// ----------------------------------------------------------------------------
// pfa channels: valid/ready interfaces of the prime field alu
// Request, response and register write channels, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface pfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfa_pkg::ACT_W-1:0]     action;
   logic [pfa_pkg::ELEM_W-1:0]    x;
   logic [pfa_pkg::ELEM_W-1:0]    y;
   logic signed [pfa_pkg::WORD_W-1:0] n;

   modport source (output valid, action, x, y, n, input ready);
   modport sink   (input valid, action, x, y, n, output ready);
endinterface

interface pfa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pfa_pkg::ELEM_W-1:0] value;
   logic                       is_zero;

   modport source (output valid, value, is_zero, input ready);
   modport sink   (input valid, value, is_zero, output ready);
endinterface

interface pfa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pfa_pkg::ELEM_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* design/prime_field_alu.sv */
// ----------------------------------------------------------------------------
// prime_field_alu: arithmetic unit for the prime field GF(p)
// Add, multiply, negate, integer mapping, zero test and Fermat inversion,
// all on one bit-serial modular multiply / reduce unit.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one response beat. Every
// operation runs as phases on a single bit-serial modular unit that handles
// one operand bit per cycle. Add reduces x + y; negate and zero test reduce x;
// multiply reduces x, then multiplies y by it; integer mapping reduces the
// magnitude of n; inversion reduces x, then squares and multiplies over p - 2
// from the lsb, multiplying per set bit and squaring per bit below the top.
// The response sits in an output register, so a new request is taken while
// it waits. The modulus register accepts a write in every cycle; values 0 and
// 1 act as 2, and it may only be written while no request is outstanding.
module prime_field_alu (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req,
   pfa_rsp_if.source rsp,
   pfa_csr_if.sink   csr
);

   pfa_pkg::pfa_state_type state_ff, state_in;

   logic                         wait_ff;
   logic [pfa_pkg::ELEM_W-1:0]   p_ff;
   logic [pfa_pkg::ACT_W-1:0]    act_ff;
   logic [pfa_pkg::ELEM_W-1:0]   x_ff;
   logic [pfa_pkg::ELEM_W-1:0]   y_ff;
   logic                         neg_ff;
   logic [pfa_pkg::WORD_W-1:0]   mag_ff;
   logic [pfa_pkg::ELEM_W-1:0]   base_ff;
   logic [pfa_pkg::ELEM_W-1:0]   acc_ff;
   logic [pfa_pkg::ELEM_W-1:0]   exp_ff;
   logic [pfa_pkg::ELEM_W-1:0]   res_val_ff;
   logic                         res_zero_ff;
   logic                         rsp_valid_ff;
   logic [pfa_pkg::ELEM_W-1:0]   rsp_value_ff;
   logic                         rsp_zero_ff;

   logic                         req_fire;
   logic                         out_free;
   logic                         mul_fin;
   logic                         u_start;
   pfa_pkg::pfa_cmd_type         u_cmd;
   pfa_pkg::pfa_res_type         u_res;
   logic [pfa_pkg::WORD_W-1:0]   n_bits;
   logic [pfa_pkg::ELEM_W:0]     xy_sum;
   logic [pfa_pkg::ELEM_W-1:0]   p_minus;

   assign n_bits   = req.n;
   assign req_fire = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign xy_sum   = {1'b0, x_ff} + {1'b0, y_ff};
   // p minus the unit result, used by negate and negative integer mapping
   assign p_minus  = (u_res.value == '0) ? '0 : (p_ff - u_res.value);
   // an exponent bit that is clear skips the multiply phase
   assign mul_fin  = wait_ff ? u_res.done : !exp_ff[0];

   pfa_mulred u_mulred (
      .clock   (clock),
      .reset   (reset),
      .start   (u_start),
      .cmd     (u_cmd),
      .modulus (p_ff),
      .res     (u_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req.action)
                  pfa_pkg::ACT_ADD: state_in = pfa_pkg::ST_ADD;
                  pfa_pkg::ACT_MUL,
                  pfa_pkg::ACT_NEG,
                  pfa_pkg::ACT_ZERO,
                  pfa_pkg::ACT_INV: state_in = pfa_pkg::ST_REDX;
                  pfa_pkg::ACT_MAP: state_in = pfa_pkg::ST_MAP;
                  default:          state_in = pfa_pkg::ST_DONE;
               endcase
            end
         end
         pfa_pkg::ST_ADD,
         pfa_pkg::ST_MAP,
         pfa_pkg::ST_MULT: begin
            if (u_res.done) state_in = pfa_pkg::ST_DONE;
         end
         pfa_pkg::ST_REDX: begin
            if (u_res.done) begin
               priority if (act_ff == pfa_pkg::ACT_MUL) begin
                  state_in = pfa_pkg::ST_MULT;
               end else if (act_ff == pfa_pkg::ACT_INV && p_ff != pfa_pkg::ELEM_TWO) begin
                  state_in = pfa_pkg::ST_INV_MUL;
               end else begin
                  state_in = pfa_pkg::ST_DONE;
               end
            end
         end
         pfa_pkg::ST_INV_MUL: begin
            if (mul_fin) begin
               state_in = (exp_ff[pfa_pkg::ELEM_W-1:1] == '0) ? pfa_pkg::ST_DONE
                                                             : pfa_pkg::ST_INV_SQR;
            end
         end
         pfa_pkg::ST_INV_SQR: begin
            if (u_res.done) state_in = pfa_pkg::ST_INV_MUL;
         end
         pfa_pkg::ST_DONE: begin
            if (out_free) state_in = pfa_pkg::ST_IDLE;
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // outputs: unit launches and request ready
   always_comb begin
      u_start = 1'b0;
      u_cmd   = '{bits: '0, count: pfa_pkg::CNT_ELEM, addend: pfa_pkg::ELEM_ONE};
      unique case (state_ff)
         pfa_pkg::ST_ADD: begin
            u_start    = !wait_ff;
            u_cmd.bits = {xy_sum, {(pfa_pkg::WORD_W - pfa_pkg::ELEM_W - 1){1'b0}}};
            u_cmd.count = pfa_pkg::CNT_SUM;
         end
         pfa_pkg::ST_REDX: begin
            u_start    = !wait_ff;
            u_cmd.bits = {x_ff, {(pfa_pkg::WORD_W - pfa_pkg::ELEM_W){1'b0}}};
         end
         pfa_pkg::ST_MAP: begin
            u_start     = !wait_ff;
            u_cmd.bits  = mag_ff;
            u_cmd.count = pfa_pkg::CNT_WORD;
         end
         pfa_pkg::ST_MULT: begin
            u_start      = !wait_ff;
            u_cmd.bits   = {y_ff, {(pfa_pkg::WORD_W - pfa_pkg::ELEM_W){1'b0}}};
            u_cmd.addend = base_ff;
         end
         pfa_pkg::ST_INV_MUL: begin
            u_start      = !wait_ff && exp_ff[0];
            u_cmd.bits   = {acc_ff, {(pfa_pkg::WORD_W - pfa_pkg::ELEM_W){1'b0}}};
            u_cmd.addend = base_ff;
         end
         pfa_pkg::ST_INV_SQR: begin
            u_start      = !wait_ff;
            u_cmd.bits   = {base_ff, {(pfa_pkg::WORD_W - pfa_pkg::ELEM_W){1'b0}}};
            u_cmd.addend = base_ff;
         end
         default: u_start = 1'b0;
      endcase
   end

   assign req.ready   = (state_ff == pfa_pkg::ST_IDLE);
   assign csr.ready   = 1'b1;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.value   = rsp_value_ff;
   assign rsp.is_zero = rsp_zero_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         wait_ff      <= 1'b0;
         p_ff         <= pfa_pkg::ELEM_TWO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (u_start) begin
            wait_ff <= 1'b1;
         end else if (u_res.done) begin
            wait_ff <= 1'b0;
         end
         if (csr.valid && csr.ready) begin
            p_ff <= (csr.data < pfa_pkg::ELEM_TWO) ? pfa_pkg::ELEM_TWO : csr.data;
         end
         if (state_ff == pfa_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == pfa_pkg::ST_DONE && out_free) begin
         rsp_value_ff <= res_val_ff;
         rsp_zero_ff  <= res_zero_ff;
      end
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (req_fire) begin
               act_ff      <= req.action;
               x_ff        <= req.x;
               y_ff        <= req.y;
               neg_ff      <= n_bits[pfa_pkg::WORD_W-1];
               mag_ff      <= n_bits[pfa_pkg::WORD_W-1] ? (~n_bits + 1'b1) : n_bits;
               res_val_ff  <= '0;
               res_zero_ff <= 1'b0;
            end
         end
         pfa_pkg::ST_ADD,
         pfa_pkg::ST_MULT: begin
            if (u_res.done) res_val_ff <= u_res.value;
         end
         pfa_pkg::ST_MAP: begin
            if (u_res.done) res_val_ff <= neg_ff ? p_minus : u_res.value;
         end
         pfa_pkg::ST_REDX: begin
            if (u_res.done) begin
               unique case (act_ff)
                  pfa_pkg::ACT_MUL: base_ff <= u_res.value;
                  pfa_pkg::ACT_NEG: res_val_ff <= p_minus;
                  pfa_pkg::ACT_ZERO: begin
                     res_val_ff  <= u_res.value;
                     res_zero_ff <= (u_res.value == '0);
                  end
                  pfa_pkg::ACT_INV: begin
                     base_ff    <= u_res.value;
                     acc_ff     <= pfa_pkg::ELEM_ONE;
                     exp_ff     <= p_ff - pfa_pkg::ELEM_TWO;
                     res_val_ff <= pfa_pkg::ELEM_ONE;
                  end
                  default: res_val_ff <= '0;
               endcase
            end
         end
         pfa_pkg::ST_INV_MUL: begin
            if (mul_fin) begin
               if (wait_ff) begin
                  acc_ff     <= u_res.value;
                  res_val_ff <= u_res.value;
               end else begin
                  res_val_ff <= acc_ff;
               end
            end
         end
         pfa_pkg::ST_INV_SQR: begin
            if (u_res.done) begin
               base_ff <= u_res.value;
               exp_ff  <= {1'b0, exp_ff[pfa_pkg::ELEM_W-1:1]};
            end
         end
         default: begin
         end
      endcase
   end

   // a taken request always leaves idle
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != pfa_pkg::ST_IDLE)
      else $error("request taken but sequencer stayed idle");

   // no unit phase is outstanding outside the working states
   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfa_pkg::ST_IDLE || state_ff == pfa_pkg::ST_DONE) |-> !wait_ff)
      else $error("unit phase outstanding while idle or done");

   // the unit only finishes a phase that the sequencer launched
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      u_res.done |-> wait_ff)
      else $error("unit finished without a launched phase");

endmodule

/* design/pfa_mulred.sv */
// ----------------------------------------------------------------------------
// pfa_mulred: bit-serial modular multiply / reduce unit
// Computes (bits * addend) mod p, one bit of bits per cycle from the msb,
// keeping the running remainder below p. With addend one it reduces bits.
// ----------------------------------------------------------------------------
module pfa_mulred (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pfa_pkg::pfa_cmd_type       cmd,
   input  logic [pfa_pkg::ELEM_W-1:0] modulus,
   output pfa_pkg::pfa_res_type       res
);

   logic [pfa_pkg::WORD_W-1:0] sh_ff, sh_in;
   logic [pfa_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pfa_pkg::ELEM_W-1:0] add_ff, add_in;
   logic [pfa_pkg::ELEM_W-1:0] acc_ff, acc_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;

   logic [pfa_pkg::ELEM_W+1:0] sum;
   logic [pfa_pkg::ELEM_W+2:0] dif1;
   logic [pfa_pkg::ELEM_W+2:0] dif2;
   logic [pfa_pkg::ELEM_W-1:0] step;

   // 2r + a stays below 3p, so at most two subtractions of p
   always_comb begin
      sum  = {1'b0, acc_ff, 1'b0} + {2'b00, (sh_ff[pfa_pkg::WORD_W-1] ? add_ff : '0)};
      dif1 = {1'b0, sum} - {3'b000, modulus};
      dif2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
      priority if (!dif2[pfa_pkg::ELEM_W+2]) begin
         step = dif2[pfa_pkg::ELEM_W-1:0];
      end else if (!dif1[pfa_pkg::ELEM_W+2]) begin
         step = dif1[pfa_pkg::ELEM_W-1:0];
      end else begin
         step = sum[pfa_pkg::ELEM_W-1:0];
      end
   end

   always_comb begin
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      add_in  = add_ff;
      acc_in  = acc_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in  = cmd.bits;
         cnt_in = cmd.count;
         add_in = cmd.addend;
         acc_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         sh_in  = {sh_ff[pfa_pkg::WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         acc_in = step;
         if (cnt_ff == pfa_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      add_ff <= add_in;
      acc_ff <= acc_in;
   end

   assign res.done  = done_ff;
   assign res.value = acc_ff;

endmodule

/* bench/tb_prime_field_alu.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prime_field_alu: self-checking bench for the GF(p) arithmetic unit
// Drives directed corner cases and then random requests over a series of
// moduli and handshake idling patterns. Each request is predicted in the
// scoreboard and the responses are compared in order, field by field.
// ----------------------------------------------------------------------------

localparam logic [pfa_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd6;
localparam logic [pfa_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd7;

typedef struct packed {
   logic [pfa_pkg::ACT_W-1:0]  action;
   logic [pfa_pkg::ELEM_W-1:0] value;
   logic                       is_zero;
} field_result_type;

class field_scoreboard;
   logic [pfa_pkg::ELEM_W-1:0] modulus_reg;
   field_result_type           expected_q[$];
   int                         mismatches;
   int                         checked;
   int                         action_count[8];

   function new();
      modulus_reg = pfa_pkg::ELEM_TWO;
      mismatches  = 0;
      checked     = 0;
      foreach (action_count[i]) action_count[i] = 0;
   endfunction

   function void set_modulus(logic [pfa_pkg::ELEM_W-1:0] v);
      modulus_reg = v;
   endfunction

   function int outstanding();
      return expected_q.size();
   endfunction

   function field_result_type field_op(logic [pfa_pkg::ACT_W-1:0] act,
                                       logic [pfa_pkg::ELEM_W-1:0] x,
                                       logic [pfa_pkg::ELEM_W-1:0] y,
                                       logic [pfa_pkg::WORD_W-1:0] n);
      longint unsigned  p, xl, yl, xr, mag, r, acc, base, e;
      field_result_type res;
      p   = (modulus_reg < 2) ? 64'd2 : 64'(modulus_reg);
      xl  = 64'(x);
      yl  = 64'(y);
      xr  = xl % p;
      res = '{action: act, value: '0, is_zero: 1'b0};
      case (act)
         pfa_pkg::ACT_ADD:  res.value = pfa_pkg::ELEM_W'((xl + yl) % p);
         pfa_pkg::ACT_MUL:  res.value = pfa_pkg::ELEM_W'((xl * yl) % p);
         pfa_pkg::ACT_NEG:  res.value = (xr == 0) ? '0 : pfa_pkg::ELEM_W'(p - xr);
         pfa_pkg::ACT_MAP: begin
            if (!n[pfa_pkg::WORD_W-1]) begin
               res.value = pfa_pkg::ELEM_W'(64'(n) % p);
            end else begin
               // magnitude of a negative word, 2^31 for the most negative
               mag = 64'h1_0000_0000 - 64'(n);
               r   = mag % p;
               res.value = (r == 0) ? '0 : pfa_pkg::ELEM_W'(p - r);
            end
         end
         pfa_pkg::ACT_ZERO: begin
            res.value   = pfa_pkg::ELEM_W'(xr);
            res.is_zero = (xr == 0);
         end
         pfa_pkg::ACT_INV: begin
            // square-and-multiply over p - 2, lsb first
            acc  = 1;
            base = xr;
            e    = p - 2;
            while (e > 0) begin
               if ((e & 1) != 0) acc = (acc * base) % p;
               base = (base * base) % p;
               e    = e >> 1;
            end
            res.value = pfa_pkg::ELEM_W'(acc % p);
         end
         default: res.value = '0;
      endcase
      return res;
   endfunction

   function void note_request(logic [pfa_pkg::ACT_W-1:0] act,
                              logic [pfa_pkg::ELEM_W-1:0] x,
                              logic [pfa_pkg::ELEM_W-1:0] y,
                              logic [pfa_pkg::WORD_W-1:0] n);
      expected_q.push_back(field_op(act, x, y, n));
      action_count[act]++;
   endfunction

   function void check_response(logic [pfa_pkg::ELEM_W-1:0] value, logic is_zero);
      field_result_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: response beat with nothing pending: value %0d is_zero %0b",
                  $time, value, is_zero);
         mismatches++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (value !== want.value) begin
         $display("%0t: value mismatch (action %0d, p %0d): expected %0d, actual %0d",
                  $time, want.action, modulus_reg, want.value, value);
         mismatches++;
      end
      if (is_zero !== want.is_zero) begin
         $display("%0t: is_zero mismatch (action %0d, p %0d): expected %0b, actual %0b",
                  $time, want.action, modulus_reg, want.is_zero, is_zero);
         mismatches++;
      end
   endfunction
endclass

module tb_prime_field_alu;

   localparam int QUIET_LIMIT    = 8000;
   localparam int TAIL_CYCLES    = 700;
   localparam int PHASES         = 12;
   localparam int ITEMS_PER_PHASE = 112;

   logic clock;
   logic reset;

   pfa_req_if req_ch ();
   pfa_rsp_if rsp_ch ();
   pfa_csr_if csr_ch ();

   field_scoreboard            board;
   int                         send_idle_pct;
   int                         recv_stall_pct;
   int                         quiet_cycles;
   int                         modulus_writes;
   logic [pfa_pkg::ELEM_W-1:0] cur_mod;

   prime_field_alu i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // beat monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            board.set_modulus(csr_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            board.note_request(req_ch.action, req_ch.x, req_ch.y, req_ch.n);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_response(rsp_ch.value, rsp_ch.is_zero);
         end
         if ((csr_ch.valid && csr_ch.ready) || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d responses pending", $time,
                     quiet_cycles, board.outstanding());
            $display("tb_prime_field_alu: done, errors");
            $finish;
         end
      end
   end

   task automatic send_req(logic [pfa_pkg::ACT_W-1:0] act, logic [pfa_pkg::ELEM_W-1:0] x,
                           logic [pfa_pkg::ELEM_W-1:0] y, logic [pfa_pkg::WORD_W-1:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.x      <= x;
      req_ch.y      <= y;
      req_ch.n      <= n;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic write_modulus(logic [pfa_pkg::ELEM_W-1:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cur_mod = (v < 2) ? pfa_pkg::ELEM_TWO : v;
      modulus_writes++;
   endtask

   function automatic logic [pfa_pkg::ELEM_W-1:0] field_operand(
         logic [pfa_pkg::ELEM_W-1:0] p);
      case ($urandom_range(4))
         0:       return p - pfa_pkg::ELEM_ONE;
         1:       return p + pfa_pkg::ELEM_W'($urandom_range(1));
         2:       return pfa_pkg::ELEM_W'($urandom_range(3));
         default: return pfa_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [pfa_pkg::ACT_W-1:0]  act;
      logic [pfa_pkg::WORD_W-1:0] n;
      logic [pfa_pkg::ELEM_W-1:0] next_mod;
      int                         sel;

      board          = new();
      modulus_writes = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cur_mod        = pfa_pkg::ELEM_TWO;
      req_ch.valid  <= 1'b0;
      req_ch.action <= pfa_pkg::ACT_ADD;
      req_ch.x      <= '0;
      req_ch.y      <= '0;
      req_ch.n      <= '0;
      csr_ch.valid  <= 1'b0;
      csr_ch.data   <= '0;
      reset         <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // modulus at its reset value of two
      send_req(pfa_pkg::ACT_INV, 16'd0, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_MAP, 16'd0, 16'd0, 32'h8000_0000);
      send_req(pfa_pkg::ACT_NEG, 16'd1, 16'd0, 32'd0);
      wait_idle();

      write_modulus(16'd65521);
      send_req(pfa_pkg::ACT_ADD, 16'hFFFF, 16'hFFFF, 32'd0);
      send_req(pfa_pkg::ACT_ADD, 16'd0, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_MUL, 16'hFFFF, 16'hFFFF, 32'd0);
      send_req(pfa_pkg::ACT_MUL, 16'd65521, 16'd5, 32'd0);
      send_req(pfa_pkg::ACT_NEG, 16'd0, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_NEG, 16'd65521, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_NEG, 16'd1, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_MAP, 16'd0, 16'd0, 32'h7FFF_FFFF);
      send_req(pfa_pkg::ACT_MAP, 16'd0, 16'd0, 32'h8000_0000);
      // negative multiple of p maps to zero
      send_req(pfa_pkg::ACT_MAP, 16'd0, 16'd0, -32'sd65521);
      send_req(pfa_pkg::ACT_MAP, 16'd0, 16'd0, 32'hFFFF_FFFF);
      send_req(pfa_pkg::ACT_ZERO, 16'd65521, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_ZERO, 16'd0, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_ZERO, 16'hFFFF, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_INV, 16'd0, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_INV, 16'd2, 16'd0, 32'd0);
      send_req(pfa_pkg::ACT_INV, 16'hFFFF, 16'd0, 32'd0);
      send_req(ACT_SPARE_A, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_req(ACT_SPARE_B, 16'd7, 16'd9, 32'd0);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       next_mod = 16'd65521;
            1:       next_mod = 16'd3;
            2:       next_mod = 16'd0;
            3:       next_mod = 16'd251;
            4:       next_mod = 16'd65535;
            5:       next_mod = 16'd1;
            6:       next_mod = 16'd7;
            8:       next_mod = 16'd4093;
            9:       next_mod = pfa_pkg::ELEM_TWO;
            11:      next_mod = 16'd257;
            default: next_mod = pfa_pkg::ELEM_W'($urandom_range(65535));
         endcase
         write_modulus(next_mod);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            sel = $urandom_range(99);
            if (sel < 6) act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
            else act = pfa_pkg::ACT_W'($urandom_range(5));
            case ($urandom_range(3))
               0, 1: n = $urandom;
               2:    n = pfa_pkg::WORD_W'($urandom_range(200)) - 32'd100;
               default: begin
                  // around signed multiples of the modulus
                  n = pfa_pkg::WORD_W'(cur_mod) * pfa_pkg::WORD_W'($urandom_range(30000));
                  if ($urandom_range(1)) n = -n;
                  n = n + pfa_pkg::WORD_W'($urandom_range(2)) - 32'd1;
               end
            endcase
            send_req(act, field_operand(cur_mod), field_operand(cur_mod), n);
         end
         wait_idle();
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d modulus settings, %0d responses checked", modulus_writes,
               board.checked);
      $display("per action: add %0d mul %0d neg %0d map %0d zero %0d inv %0d spare %0d",
               board.action_count[pfa_pkg::ACT_ADD], board.action_count[pfa_pkg::ACT_MUL],
               board.action_count[pfa_pkg::ACT_NEG], board.action_count[pfa_pkg::ACT_MAP],
               board.action_count[pfa_pkg::ACT_ZERO], board.action_count[pfa_pkg::ACT_INV],
               board.action_count[ACT_SPARE_A] + board.action_count[ACT_SPARE_B]);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("tb_prime_field_alu: done, clean");
      end else begin
         $display("tb_prime_field_alu: done, errors");
      end
      $finish;
   end

endmodule
